[sv/fpa_pkg.sv]
// ----------------------------------------------------------------------------
// Fixed-point ALU package
// Word formats, opcodes, pipeline stage types and saturating helpers that are
// shared by the ALU modules.
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int FRACTION_BITS = 8;
  localparam int WORD_BITS     = 32;
  // Quotient bits of (|a| << FRACTION_BITS) / |b|, one per divider stage.
  localparam int QUO_BITS      = WORD_BITS + FRACTION_BITS;
  localparam int DIV_STAGES    = QUO_BITS;
  // Quotient plus the rounding carry.
  localparam int Q1_BITS       = QUO_BITS + 1;
  // Full magnitude product and its rounded, rescaled form.
  localparam int PROD_BITS     = 2 * WORD_BITS;
  localparam int Q_BITS        = PROD_BITS - FRACTION_BITS;
  localparam int OP_BITS       = 4;
  localparam int IN_DATA_BITS  = ((OP_BITS + 2 * WORD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((WORD_BITS + 3 + 7) / 8) * 8;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic [WORD_BITS-1:0] mag_t;
  typedef logic [QUO_BITS-1:0] quo_t;

  localparam word_t MAX_WORD = {1'b0, {(WORD_BITS - 1){1'b1}}};
  localparam word_t MIN_WORD = {1'b1, {(WORD_BITS - 1){1'b0}}};
  localparam mag_t  SIGN_MAG = {1'b1, {(WORD_BITS - 1){1'b0}}};

  typedef enum logic [OP_BITS-1:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_EQ       = 4'd4,
    OP_NE       = 4'd5,
    OP_GT       = 4'd6,
    OP_LT       = 4'd7,
    OP_GE       = 4'd8,
    OP_LE       = 4'd9,
    OP_MIN      = 4'd10,
    OP_MAX      = 4'd11,
    OP_INC      = 4'd12,
    OP_DEC      = 4'd13,
    OP_FROM_INT = 4'd14,
    OP_TO_INT   = 4'd15
  } op_t;

  // Saturated value with its overflow flag.
  typedef struct packed {
    word_t value;
    logic  ovf;
  } sat_t;

  // Control and early result that travel beside the divider.
  typedef struct packed {
    logic  valid;
    op_t   op;
    logic  neg;   // sign of a product or quotient
    logic  na;    // sign of operand_a
    logic  dz;    // divide with zero divisor
    word_t res;
    logic  cmp;
    logic  ovf;
  } side_t;

  // One restoring divider stage.
  typedef struct packed {
    quo_t num;
    mag_t rem;
    quo_t quo;
    mag_t den;
  } div_t;

  function automatic mag_t mag_of(word_t x);
    mag_t m;
    m = mag_t'(x);
    return x[WORD_BITS-1] ? (~m + mag_t'(1)) : m;
  endfunction

  function automatic sat_t add_sat(word_t a, word_t b, logic sub);
    word_t r;
    logic  ovf;
    sat_t  s;
    r = sub ? (a - b) : (a + b);
    if (sub) begin
      ovf = (a[WORD_BITS-1] != b[WORD_BITS-1]) && (r[WORD_BITS-1] != a[WORD_BITS-1]);
    end else begin
      ovf = (a[WORD_BITS-1] == b[WORD_BITS-1]) && (r[WORD_BITS-1] != a[WORD_BITS-1]);
    end
    s.value = ovf ? (a[WORD_BITS-1] ? MIN_WORD : MAX_WORD) : r;
    s.ovf   = ovf;
    return s;
  endfunction

endpackage

[sv/fixed_point_alu_q24_8_top.sv]
// ----------------------------------------------------------------------------
// Fixed-point ALU, Q24.8, top level
// A new word can enter every clock cycle while the output is not stalled; each
// word passes the input register, the side pipeline and the output register and
// comes out in order, whatever its operation. The depth of that pipeline is set
// by the divider, which retires one quotient bit per stage; all other operations
// ride alongside it. The whole pipeline holds while a result waits on m_tready,
// and s_tready is low for exactly those cycles.
// ----------------------------------------------------------------------------
module fixed_point_alu_q24_8_top import fpa_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // op, operand_a, operand_b, zero fill
  input  logic [IN_DATA_BITS-1:0]  s_tdata,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // result_value, compare_true, overflowed, divide_by_zero, zero fill
  output logic [OUT_DATA_BITS-1:0] m_tdata
);

  logic  ce;
  side_t f_side;
  mag_t  f_mag_a;
  mag_t  f_mag_b;
  side_t p0;
  mag_t  p0_mag_a;
  mag_t  p0_mag_b;
  side_t side [1:DIV_STAGES];
  sat_t  mul_res;
  div_t  div_last;
  logic  [Q1_BITS-1:0] q1;
  logic  round_up;
  logic  q_ovf;
  word_t fin_res;
  logic  fin_cmp;
  logic  fin_ovf;
  logic  fin_dz;
  word_t out_res;
  logic  out_cmp;
  logic  out_ovf;
  logic  out_dz;
  logic  out_valid;

  // The pipeline advances unless a result is stuck at the output.
  assign ce       = !out_valid || m_tready;
  assign s_tready = ce;

  fpa_front u_front (
    .valid     (s_tvalid),
    .op        (op_t'(s_tdata[OP_BITS-1:0])),
    .operand_a (word_t'(s_tdata[OP_BITS +: WORD_BITS])),
    .operand_b (word_t'(s_tdata[OP_BITS + WORD_BITS +: WORD_BITS])),
    .side      (f_side),
    .mag_a     (f_mag_a),
    .mag_b     (f_mag_b)
  );

  // Input register stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      p0.valid <= 1'b0;
    end else if (ce) begin
      p0       <= f_side;
      p0_mag_a <= f_mag_a;
      p0_mag_b <= f_mag_b;
    end
  end

  fpa_mul u_mul (
    .clk    (clk),
    .ce     (ce),
    .mag_a  (p0_mag_a),
    .mag_b  (p0_mag_b),
    .neg    (p0.neg),
    .result (mul_res)
  );

  fpa_div u_div (
    .clk   (clk),
    .ce    (ce),
    .mag_a (p0_mag_a),
    .mag_b (p0_mag_b),
    .last  (div_last)
  );

  // Side pipeline; the product joins at stage three.
  for (genvar i = 1; i <= DIV_STAGES; i++) begin : g_side
    side_t side_next;

    if (i == 1) begin : g_first
      assign side_next = p0;
    end else if (i == 3) begin : g_join
      always_comb begin
        side_next = side[i-1];
        if (side[i-1].op == OP_MUL) begin
          side_next.res = mul_res.value;
          side_next.ovf = mul_res.ovf;
        end
      end
    end else begin : g_pass
      assign side_next = side[i-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        side[i].valid <= 1'b0;
      end else if (ce) begin
        side[i] <= side_next;
      end
    end
  end

  // Quotient rounding: round up when twice the remainder reaches the divisor.
  assign round_up = {div_last.rem, 1'b0} >= {1'b0, div_last.den};
  assign q1       = {1'b0, div_last.quo} + Q1_BITS'(round_up);
  assign q_ovf    = side[DIV_STAGES].neg ? (q1 > Q1_BITS'(SIGN_MAG))
                                         : (q1 > Q1_BITS'(MAX_WORD));

  // Final select.
  always_comb begin
    fin_res = side[DIV_STAGES].res;
    fin_cmp = side[DIV_STAGES].cmp;
    fin_ovf = side[DIV_STAGES].ovf;
    fin_dz  = 1'b0;
    if (side[DIV_STAGES].op == OP_DIV) begin
      fin_cmp = 1'b0;
      if (side[DIV_STAGES].dz) begin
        fin_res = side[DIV_STAGES].na ? MIN_WORD : MAX_WORD;
        fin_ovf = 1'b1;
        fin_dz  = 1'b1;
      end else if (q_ovf) begin
        fin_res = side[DIV_STAGES].neg ? MIN_WORD : MAX_WORD;
        fin_ovf = 1'b1;
      end else begin
        fin_res = side[DIV_STAGES].neg ? word_t'(~q1[WORD_BITS-1:0] + mag_t'(1))
                                       : word_t'(q1[WORD_BITS-1:0]);
        fin_ovf = 1'b0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ce) begin
      out_valid <= side[DIV_STAGES].valid;
      out_res   <= fin_res;
      out_cmp   <= fin_cmp;
      out_ovf   <= fin_ovf;
      out_dz    <= fin_dz;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_DATA_BITS'({out_dz, out_ovf, out_cmp, out_res});

endmodule

[sv/fpa_front.sv]
// ----------------------------------------------------------------------------
// Fixed-point ALU front end
// Decodes a word and computes the combinational operations: add, subtract,
// compares, min, max, increment, decrement and the integer conversions.
// ----------------------------------------------------------------------------
module fpa_front import fpa_pkg::*; (
  input  logic  valid,
  input  op_t   op,
  input  word_t operand_a,
  input  word_t operand_b,
  output side_t side,
  output mag_t  mag_a,
  output mag_t  mag_b
);

  sat_t  sum;
  sat_t  diff;
  sat_t  incr;
  sat_t  decr;
  mag_t  int_mag;
  word_t int_val;
  logic  from_ovf;
  logic  lt;
  logic  gt;
  logic  [FRACTION_BITS:0] top_bits;

  assign mag_a = mag_of(operand_a);
  assign mag_b = mag_of(operand_b);

  // Saturating adders.
  assign sum  = add_sat(operand_a, operand_b, 1'b0);
  assign diff = add_sat(operand_a, operand_b, 1'b1);
  assign incr = add_sat(operand_a, word_t'(1), 1'b0);
  assign decr = add_sat(operand_a, word_t'(1), 1'b1);

  assign lt = operand_a < operand_b;
  assign gt = operand_a > operand_b;

  // Integer to fixed overflows unless the shifted-out bits copy the sign.
  assign top_bits = operand_a[WORD_BITS-1 -: (FRACTION_BITS + 1)];
  assign from_ovf = (top_bits != '0) && (top_bits != '1);

  // Fixed to integer truncates the magnitude, so it rounds toward zero.
  assign int_mag = mag_a >> FRACTION_BITS;
  assign int_val = operand_a[WORD_BITS-1] ? word_t'(~int_mag + mag_t'(1)) : word_t'(int_mag);

  // Result select.
  always_comb begin
    side       = '0;
    side.valid = valid;
    side.op    = op;
    side.neg   = operand_a[WORD_BITS-1] ^ operand_b[WORD_BITS-1];
    side.na    = operand_a[WORD_BITS-1];
    side.dz    = (op == OP_DIV) && (mag_b == '0);
    unique case (op)
      OP_ADD: begin
        side.res = sum.value;
        side.ovf = sum.ovf;
      end
      OP_SUB: begin
        side.res = diff.value;
        side.ovf = diff.ovf;
      end
      OP_EQ: side.cmp = operand_a == operand_b;
      OP_NE: side.cmp = operand_a != operand_b;
      OP_GT: side.cmp = gt;
      OP_LT: side.cmp = lt;
      OP_GE: side.cmp = !lt;
      OP_LE: side.cmp = !gt;
      OP_MIN: side.res = lt ? operand_a : operand_b;
      OP_MAX: side.res = gt ? operand_a : operand_b;
      OP_INC: begin
        side.res = incr.value;
        side.ovf = incr.ovf;
      end
      OP_DEC: begin
        side.res = decr.value;
        side.ovf = decr.ovf;
      end
      OP_FROM_INT: begin
        side.res = from_ovf ? (operand_a[WORD_BITS-1] ? MIN_WORD : MAX_WORD)
                            : (operand_a <<< FRACTION_BITS);
        side.ovf = from_ovf;
      end
      OP_TO_INT: side.res = int_val;
      default: side.res = '0;
    endcase
  end

endmodule

[sv/fpa_mul.sv]
// ----------------------------------------------------------------------------
// Fixed-point ALU multiplier
// Two register stages: magnitude product, then rounding half away from zero,
// sign and saturation.
// ----------------------------------------------------------------------------
module fpa_mul import fpa_pkg::*; (
  input  logic clk,
  input  logic ce,
  input  mag_t mag_a,
  input  mag_t mag_b,
  input  logic neg,
  output sat_t result
);

  logic [PROD_BITS-1:0] prod;
  logic                 prod_neg;
  logic [PROD_BITS-1:0] rounded;
  logic [Q_BITS-1:0]    q;
  logic                 ovf;

  // Stage one: unsigned product.
  always_ff @(posedge clk) begin
    if (ce) begin
      prod     <= PROD_BITS'(mag_a) * PROD_BITS'(mag_b);
      prod_neg <= neg;
    end
  end

  // Stage two: round, apply sign, saturate.
  assign rounded = prod + (PROD_BITS'(1) << (FRACTION_BITS - 1));
  assign q       = rounded[PROD_BITS-1:FRACTION_BITS];
  assign ovf     = prod_neg ? (q > Q_BITS'(SIGN_MAG)) : (q > Q_BITS'(MAX_WORD));

  always_ff @(posedge clk) begin
    if (ce) begin
      result.ovf <= ovf;
      if (ovf) begin
        result.value <= prod_neg ? MIN_WORD : MAX_WORD;
      end else begin
        result.value <= prod_neg ? word_t'(~q[WORD_BITS-1:0] + mag_t'(1))
                                 : word_t'(q[WORD_BITS-1:0]);
      end
    end
  end

endmodule

[sv/fpa_div.sv]
// ----------------------------------------------------------------------------
// Fixed-point ALU divider
// Pipelined restoring divider on magnitudes: each stage retires one quotient
// bit of (|a| << FRACTION_BITS) / |b| with one compare and subtract.
// ----------------------------------------------------------------------------
module fpa_div import fpa_pkg::*; (
  input  logic clk,
  input  logic ce,
  input  mag_t mag_a,
  input  mag_t mag_b,
  output div_t last
);

  div_t stage [DIV_STAGES+1];

  // Entry point of the divider.
  always_comb begin
    stage[0].num = quo_t'(mag_a) << FRACTION_BITS;
    stage[0].rem = '0;
    stage[0].quo = '0;
    stage[0].den = mag_b;
  end

  for (genvar i = 1; i <= DIV_STAGES; i++) begin : g_step
    logic [WORD_BITS:0] trial;
    logic               take;

    assign trial = {stage[i-1].rem, stage[i-1].num[QUO_BITS-1]};
    assign take  = trial >= {1'b0, stage[i-1].den};

    // One quotient bit per stage.
    always_ff @(posedge clk) begin
      if (ce) begin
        stage[i].num <= stage[i-1].num << 1;
        stage[i].den <= stage[i-1].den;
        stage[i].quo <= {stage[i-1].quo[QUO_BITS-2:0], take};
        stage[i].rem <= take ? mag_t'(trial - {1'b0, stage[i-1].den}) : trial[WORD_BITS-1:0];
      end
    end
  end

  assign last = stage[DIV_STAGES];

endmodule

[sv/fpa_checker.sv]
// ----------------------------------------------------------------------------
// Fixed-point ALU port checker
// Watches the top-level ports for flag consistency and stall behavior.
// ----------------------------------------------------------------------------
module fpa_checker import fpa_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     s_tready,
  input logic                     m_tvalid,
  input logic                     m_tready,
  input logic [OUT_DATA_BITS-1:0] m_tdata
);

  // A held result keeps its word.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output word changed while stalled");

  // A stalled output stops intake.
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input accepted while output stalled");

  // Zero divisor always saturates.
  a_dz_ovf: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[WORD_BITS+2] |-> m_tdata[WORD_BITS+1])
    else $error("divide by zero without overflow");

  // Compares give a zero value and no flags.
  a_cmp_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[WORD_BITS] |->
      m_tdata[WORD_BITS-1:0] == '0 && !m_tdata[WORD_BITS+1] && !m_tdata[WORD_BITS+2])
    else $error("compare result carries value or flags");

endmodule

bind fixed_point_alu_q24_8_top fpa_checker u_fpa_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
